// File: rtl/core/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int CP_W      = 21;
	localparam int MAX_RES   = 4;
	localparam int CNT_W     = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [CP_W-1:0] HEADER_WORD = 21'h00FEFF;
	localparam logic [CP_W-1:0] ESCAPE_BASE = 21'h00DC00;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EMIT_HEADER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_BOM   = 1'b1;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            esc;
	} res_t;

	// all results caused by one item
	typedef struct packed {
		res_t [MAX_RES-1:0] ent;
		logic [CNT_W-1:0]   cnt;
		logic               last;
	} dec_out_t;

	function automatic logic [CP_W-1:0] escape_of(input logic [7:0] b);
		escape_of = ESCAPE_BASE + {{(CP_W-8){1'b0}}, b};
	endfunction

endpackage

// File: rtl/core/utf8_to_codepoint_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// Turns a UTF-8 byte stream into 21-bit code points, escaping bad bytes.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid/in_ready carries data_byte and stream_end, one
//   byte per item; stream_end marks the last byte and flushes held bytes.
//   output channel out_valid/out_ready carries code_point, escaped, run_last
//   and stream_last, one result per item; a byte gives zero to four results.
//   config channel cfg_valid/cfg_ready writes cfg_data into register
//   cfg_index (0 header word enable, 1 leading BOM strip); always ready,
//   write only while the block is idle.
// Timing:
//   a byte is held in the input register and decoded combinationally into the
//   result register, from which its first result is shown on the output. One
//   byte per cycle is taken as long as each byte gives at most one result and
//   the receiver takes each result; a byte with more results holds the result
//   register until its last result is taken, since the output port moves one
//   result per cycle.
// Reset clears held bytes, rearms header and BOM handling, sets both config
//   bits to 1. A stalled receiver holds the current result; the input
//   register then fills and in_ready drops.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              stream_end,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [utf8d_pkg::CP_W-1:0]        code_point,
	output logic                              escaped,
	output logic                              run_last,
	output logic                              stream_last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [utf8d_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic                              cfg_data
);
	import utf8d_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       load_ok;
	logic       adv;
	logic       cfg_hdr_q;
	logic       cfg_strip_q;
	dec_out_t   dec;

	assign cfg_ready = 1'b1;
	assign in_ready  = !vld_s1 || load_ok;
	assign adv       = vld_s1 && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			end_s1  <= stream_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_hdr_q   <= 1'b1;
			cfg_strip_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EMIT_HEADER: cfg_hdr_q   <= cfg_data;
				REG_STRIP_BOM:   cfg_strip_q <= cfg_data;
				default: ;
			endcase
		end
	end

	utf8d_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.byte_s1   (byte_s1),
		.end_s1    (end_s1),
		.cfg_hdr   (cfg_hdr_q),
		.cfg_strip (cfg_strip_q),
		.dec       (dec)
	);

	utf8d_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (adv),
		.dec         (dec),
		.load_ok     (load_ok),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_point  (code_point),
		.escaped     (escaped),
		.run_last    (run_last),
		.stream_last (stream_last)
	);

endmodule

// File: rtl/core/utf8d_decode.sv
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and single-pass decode of one byte into its list of results.
// ----------------------------------------------------------------------------
module utf8d_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [7:0]          byte_s1,
	input  logic                end_s1,
	input  logic                cfg_hdr,
	input  logic                cfg_strip,
	output utf8d_pkg::dec_out_t dec
);
	import utf8d_pkg::*;

	logic [7:0]      held_q [3];
	logic [1:0]      hc_q;
	logic [2:0]      len_q;
	logic            start_q;
	logic            first_q;

	logic [7:0]      held_d [3];
	logic [1:0]      hc_d;
	logic [1:0]      hc_n;
	logic [2:0]      len_d;
	logic [2:0]      len_n;
	logic            start_d;
	logic            first_d;

	logic [7:0]      lead_m;
	logic [31:0]     seq_w;
	logic [CP_W-1:0] seq_cp;

	logic [7:0]      slot_v;
	logic [CP_W-1:0] slot_cp [8];
	logic [7:0]      slot_esc;

	logic            brk;
	logic            byte_emit;
	logic            byte_code;
	logic [CP_W-1:0] byte_val;
	logic            drop;

	logic [CNT_W-1:0]   n;
	res_t [MAX_RES-1:0] ent;

	// value of the completed sequence
	always_comb begin
		lead_m = held_q[0] & (8'h7F >> len_q);
		case (hc_q)
			2'd1:    seq_w = {18'b0, lead_m, byte_s1[5:0]};
			2'd2:    seq_w = {12'b0, lead_m, held_q[1][5:0], byte_s1[5:0]};
			2'd3:    seq_w = {6'b0, lead_m, held_q[1][5:0], held_q[2][5:0], byte_s1[5:0]};
			default: seq_w = '0;
		endcase
		seq_cp = seq_w[CP_W-1:0];
	end

	always_comb begin
		slot_v    = '0;
		slot_esc  = '0;
		for (int i = 0; i < 8; i++) begin
			slot_cp[i] = '0;
		end
		held_d    = held_q;
		hc_d      = hc_q;
		len_d     = len_q;
		brk       = 1'b0;
		byte_emit = 1'b0;
		byte_code = 1'b0;
		byte_val  = '0;

		if (start_q && cfg_hdr) begin
			slot_v[0]  = 1'b1;
			slot_cp[0] = HEADER_WORD;
		end

		if (hc_q == 2'd0) begin
			if (!byte_s1[7]) begin
				byte_emit = 1'b1;
				byte_code = 1'b1;
				byte_val  = {{(CP_W-8){1'b0}}, byte_s1};
			end else if (!byte_s1[6] || byte_s1[7:3] == 5'h1F) begin
				byte_emit = 1'b1;
				byte_val  = escape_of(byte_s1);
			end else begin
				// lead byte: start a sequence
				held_d[0] = byte_s1;
				hc_d      = 2'd1;
				if (!byte_s1[5])
					len_d = 3'd2;
				else if (!byte_s1[4])
					len_d = 3'd3;
				else
					len_d = 3'd4;
			end
		end else if (byte_s1[7:6] == 2'b10) begin
			if (({1'b0, hc_q} + 3'd1 >= len_q) || hc_q == 2'd3) begin
				byte_emit = 1'b1;
				byte_code = 1'b1;
				byte_val  = seq_cp;
				hc_d      = 2'd0;
				len_d     = 3'd0;
			end else begin
				held_d[hc_q] = byte_s1;
				hc_d         = hc_q + 2'd1;
			end
		end else begin
			// sequence broken: held bytes escape first
			brk       = 1'b1;
			hc_d      = 2'd0;
			len_d     = 3'd0;
			byte_emit = 1'b1;
			byte_code = !byte_s1[7];
			byte_val  = byte_s1[7] ? escape_of(byte_s1) : {{(CP_W-8){1'b0}}, byte_s1};
		end

		for (int k = 0; k < 3; k++) begin
			slot_v[1+k]   = brk && (2'(k) < hc_q);
			slot_cp[1+k]  = escape_of(held_q[k]);
			slot_esc[1+k] = 1'b1;
		end

		drop = byte_code && first_q && !brk && cfg_strip && (byte_val == HEADER_WORD);
		slot_v[4]   = byte_emit && !drop;
		slot_cp[4]  = byte_val;
		slot_esc[4] = !byte_code;

		// flush at end of stream
		for (int k = 0; k < 3; k++) begin
			slot_v[5+k]   = end_s1 && (2'(k) < hc_d);
			slot_cp[5+k]  = escape_of(held_d[k]);
			slot_esc[5+k] = 1'b1;
		end

		hc_n    = end_s1 ? 2'd0 : hc_d;
		len_n   = end_s1 ? 3'd0 : len_d;
		start_d = end_s1;
		first_d = end_s1 ? 1'b1 : (first_q && !byte_emit && !brk);
	end

	// pack the valid slots in order
	always_comb begin
		n   = '0;
		ent = '0;
		for (int i = 0; i < 8; i++) begin
			if (slot_v[i] && n < CNT_W'(MAX_RES)) begin
				ent[n[1:0]].cp  = slot_cp[i];
				ent[n[1:0]].esc = slot_esc[i];
				n = n + 3'd1;
			end
		end
		dec.ent  = ent;
		dec.cnt  = n;
		dec.last = end_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q[0] <= '0;
			held_q[1] <= '0;
			held_q[2] <= '0;
			hc_q      <= '0;
			len_q     <= '0;
			start_q   <= 1'b1;
			first_q   <= 1'b1;
		end else if (adv) begin
			held_q  <= held_d;
			hc_q    <= hc_n;
			len_q   <= len_n;
			start_q <= start_d;
			first_q <= first_d;
		end
	end

endmodule

// File: rtl/core/utf8d_outbuf.sv
// ----------------------------------------------------------------------------
// utf8d_outbuf
// Result register: holds the results of one item and hands them out in order.
// ----------------------------------------------------------------------------
module utf8d_outbuf (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  utf8d_pkg::dec_out_t      dec,
	output logic                     load_ok,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [utf8d_pkg::CP_W-1:0] code_point,
	output logic                     escaped,
	output logic                     run_last,
	output logic                     stream_last
);
	import utf8d_pkg::*;

	res_t [MAX_RES-1:0] ent_s2;
	logic [CNT_W-1:0]   cnt_s2;
	logic               end_s2;
	logic [1:0]         idx_s2;
	logic               vld_s2;
	logic               last;

	assign last        = ({1'b0, idx_s2} + 3'd1) == cnt_s2;
	assign load_ok     = !vld_s2 || (out_ready && last);
	assign out_valid   = vld_s2;
	assign code_point  = ent_s2[idx_s2].cp;
	assign escaped     = ent_s2[idx_s2].esc;
	assign run_last    = last;
	assign stream_last = last && end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			idx_s2 <= '0;
		end else if (load) begin
			// an item with no results leaves the buffer empty
			vld_s2 <= dec.cnt != '0;
			idx_s2 <= '0;
		end else if (vld_s2 && out_ready) begin
			if (last)
				vld_s2 <= 1'b0;
			else
				idx_s2 <= idx_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_s2 <= dec.ent;
			cnt_s2 <= dec.cnt;
			end_s2 <= dec.last;
		end
	end

endmodule

// File: rtl/core/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [utf8d_pkg::CP_W-1:0]        code_point,
	input logic                              escaped,
	input logic                              run_last,
	input logic                              stream_last
);
	import utf8d_pkg::*;

	// stream end only on the last result of an item
	a_stream_last_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_last |-> run_last)
		else $error("stream_last without run_last");

	// escapes only carry bytes 0x80..0xFF
	a_escape_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && escaped |-> code_point[CP_W-1:8] == 13'h0DC && code_point[7])
		else $error("escape value out of range");

	// input only backs up behind a pending result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no pending result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(escaped))
		else $error("stalled result changed");

endmodule

bind utf8_to_codepoint_decoder utf8d_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.code_point  (code_point),
	.escaped     (escaped),
	.run_last    (run_last),
	.stream_last (stream_last)
);
